[hdl/bhr_pkg.sv]
`timescale 1ns / 1ps
package bhr_pkg;
  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int TOTAL_W = 40;

  localparam logic [1:0] MODE_COUNT = 2'd0;
  localparam logic [1:0] MODE_READ = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic       clear;
    logic       upd;
    logic [7:0] sym;
  } cell_cmd_t;
endpackage

[hdl/byte_histogram_ranked.sv]
`timescale 1ns / 1ps
// Ranked byte histogram. A word is taken when start is high and busy is low.
// A count word goes through S_LOOK (look up the old count), then S_UPD (shift the row of
// rank cells by one place in one step); a read word goes through S_RD and its
// result appears with done high for one cycle; a clear word acts as it is taken.
// The rate is set by the count lookup across the row plus the shift step.
// Results cannot be held off: sample them in the cycle done is high.
module byte_histogram_ranked import bhr_pkg::*; #(
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           mode,
  input  logic [7:0]           byte_value,
  input  logic [7:0]           rank,
  output logic                 done,
  output logic [7:0]           symbol,
  output logic [31:0]          occurrences,
  output logic                 entry_valid,
  output logic [8:0]           distinct_symbols,
  output logic [TOTAL_W-1:0]   grand_total
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_UPD = 2'd2;
  localparam logic [1:0] S_RD = 2'd3;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [TOTAL_W-1:0] TOT_MAX = {TOTAL_W{1'b1}};

  logic [1:0] state;
  logic [7:0] cur_sym;
  logic [7:0] cur_rank;
  logic [COUNT_WIDTH-1:0] old_cnt;
  logic [COUNT_WIDTH-1:0] new_cnt;
  logic [8:0] nonzero;
  logic [TOTAL_W-1:0] total;
  logic accept;
  cell_cmd_t cmd;

  logic [7:0] c_sym [SYMBOL_COUNT];
  logic [COUNT_WIDTH-1:0] c_cnt [SYMBOL_COUNT];
  logic c_nb [SYMBOL_COUNT];
  logic c_match [SYMBOL_COUNT];

  logic [COUNT_WIDTH-1:0] look_cnt;
  logic [7:0] rd_sym;
  logic [COUNT_WIDTH-1:0] rd_cnt;

  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign cmd.clear = accept && (mode == MODE_CLEAR);
  assign cmd.upd = (state == S_UPD);
  assign cmd.sym = cur_sym;

  for (genvar i = 0; i < SYMBOL_COUNT; i++) begin : g_cell
    if (i == 0) begin : g_head
      bhr_cell #(.INDEX(i), .COUNT_WIDTH(COUNT_WIDTH)) u_cell (
        .clk, .rst, .cmd, .old_cnt, .new_cnt,
        .prev_sym(8'd0), .prev_cnt('0), .prev_nb(1'b0),
        .sym(c_sym[i]), .cnt(c_cnt[i]), .nb(c_nb[i]), .match(c_match[i])
      );
    end else begin : g_body
      bhr_cell #(.INDEX(i), .COUNT_WIDTH(COUNT_WIDTH)) u_cell (
        .clk, .rst, .cmd, .old_cnt, .new_cnt,
        .prev_sym(c_sym[i-1]), .prev_cnt(c_cnt[i-1]), .prev_nb(c_nb[i-1]),
        .sym(c_sym[i]), .cnt(c_cnt[i]), .nb(c_nb[i]), .match(c_match[i])
      );
    end
  end

  always_comb begin
    look_cnt = '0;
    rd_sym = '0;
    rd_cnt = '0;
    for (int i = 0; i < SYMBOL_COUNT; i++) begin
      if (c_match[i]) look_cnt = look_cnt | c_cnt[i];
      if (cur_rank == 8'(i)) begin
        rd_sym = rd_sym | c_sym[i];
        rd_cnt = rd_cnt | c_cnt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nonzero <= '0;
      total <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur_sym <= byte_value;
            cur_rank <= rank;
            if (mode == MODE_COUNT && {1'b0, byte_value} < 9'(SYMBOL_COUNT)) begin
              state <= S_LOOK;
            end else if (mode == MODE_READ) begin
              state <= S_RD;
            end else if (mode == MODE_CLEAR) begin
              nonzero <= '0;
              total <= '0;
            end
          end
        end
        S_LOOK: begin
          old_cnt <= look_cnt;
          new_cnt <= look_cnt + 1'b1;
          // drop the word if its count is already saturated
          state <= (look_cnt == CNT_MAX) ? S_IDLE : S_UPD;
        end
        S_UPD: begin
          if (old_cnt == '0) nonzero <= nonzero + 9'd1;
          if (total != TOT_MAX) total <= total + 1'b1;
          state <= S_IDLE;
        end
        S_RD: begin
          done <= 1'b1;
          distinct_symbols <= nonzero;
          grand_total <= total;
          if ({1'b0, cur_rank} < nonzero) begin
            entry_valid <= 1'b1;
            symbol <= rd_sym;
            occurrences <= 32'(rd_cnt);
          end else begin
            entry_valid <= 1'b0;
            symbol <= '0;
            occurrences <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_READ) |=> busy) else $error("read not started");
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_RD)) else $error("stray done");
  a_nz_range: assert property (@(posedge clk) disable iff (rst)
    nonzero <= 9'(SYMBOL_COUNT)) else $error("distinct count overflow");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !entry_valid) |-> (occurrences == '0 && symbol == '0))
    else $error("invalid entry not zeroed");
endmodule

[hdl/bhr_cell.sv]
`timescale 1ns / 1ps
module bhr_cell import bhr_pkg::*; #(
  parameter int INDEX = 0,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cell_cmd_t              cmd,
  input  logic [COUNT_WIDTH-1:0] old_cnt,
  input  logic [COUNT_WIDTH-1:0] new_cnt,
  input  logic [7:0]             prev_sym,
  input  logic [COUNT_WIDTH-1:0] prev_cnt,
  input  logic                   prev_nb,
  output logic [7:0]             sym,
  output logic [COUNT_WIDTH-1:0] cnt,
  output logic                   nb,
  output logic                   match
);
  logic ahead;

  assign match = (sym == cmd.sym);
  // entry sits above the old place of the counted symbol
  assign ahead = (cnt > old_cnt) || ((cnt == old_cnt) && (sym < cmd.sym));
  // counted symbol with its new count ranks before this entry
  assign nb = (new_cnt > cnt) || ((new_cnt == cnt) && (cmd.sym < sym));

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      sym <= 8'(INDEX);
      cnt <= '0;
    end else if (cmd.upd && (ahead || match)) begin
      if (prev_nb) begin
        sym <= prev_sym;
        cnt <= prev_cnt;
      end else if (nb) begin
        sym <= cmd.sym;
        cnt <= new_cnt;
      end
    end
  end
endmodule
